[design/assert_macros.svh]
// Assertion macros shared by the current controller RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the property in the same cycle.
`define MCPI_ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// The condition implies the property in the next cycle.
`define MCPI_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/mcpi_pkg.sv]
// Package for the motor current PI controller: widths, codes and constants.
// No dependencies; used by every module of the controller.
`default_nettype none

package mcpi_pkg;

   localparam int MEAS_W     = 16;
   localparam int ERR_W      = 17;
   localparam int INTEG_W    = 24;
   localparam int GAIN_W     = 16;
   localparam int MAC_HI_W   = 27;
   localparam int U_W        = MAC_HI_W + GAIN_W;
   localparam int MAG_W      = 19;
   localparam int PERIOD_W   = 16;
   localparam int FRAC_BITS  = 12;
   localparam int DIVIDEND_W = MAG_W + PERIOD_W - FRAC_BITS;
   localparam int REM_W      = 7;
   localparam int CMP_W      = 16;
   localparam int DUTY_W     = 8;
   localparam int DUTY_MAG_W = 7;
   localparam int REF_W      = 9;
   localparam int INDEX_W    = 7;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HOLD  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TRACK = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 3'd4;

   localparam logic [GAIN_W-1:0]   PROP_GAIN_RESET  = 16'd287;
   localparam logic [GAIN_W-1:0]   INTEG_GAIN_RESET = 16'd82;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd2399;

   localparam logic signed [U_W-1:0] FULL_DRIVE     = 43'sd409600;
   localparam logic signed [U_W-1:0] FULL_DRIVE_NEG = -43'sd409600;
   localparam logic [MAG_W-1:0]      FULL_MAG       = 19'd409600;

   localparam logic signed [INTEG_W:0]   INTEG_LIMIT     = 25'sd500;
   localparam logic signed [INTEG_W:0]   INTEG_LIMIT_NEG = -25'sd500;
   localparam logic signed [INTEG_W-1:0] INTEG_MAX       = 24'sh7FFFFF;
   localparam logic signed [INTEG_W-1:0] INTEG_MIN       = 24'sh800000;

   localparam logic signed [REF_W-1:0] TEST_AMPLITUDE     = 9'sd200;
   localparam logic signed [REF_W-1:0] TEST_AMPLITUDE_NEG = -9'sd200;

   localparam logic signed [DUTY_W-1:0] DUTY_MAX = 8'sd100;
   localparam logic signed [DUTY_W-1:0] DUTY_MIN = -8'sd100;

   localparam logic [REM_W:0] PERCENT_SCALE = 8'd100;

   typedef struct packed {
      logic busy;
      logic done;
   } mcpi_unit_status_type;

endpackage

`default_nettype wire

[design/mcpi_pi_mac.sv]
// Serial multiply-accumulate for the PI drive: kp*err + ki*integral, one gain bit per cycle.
// Depends on mcpi_pkg.
`default_nettype none

module mcpi_pi_mac
   import mcpi_pkg::*;
(
   input  wire  logic                       clock,
   input  wire  logic                       reset,
   input  wire  logic                       start,
   input  wire  logic signed [ERR_W-1:0]    err,
   input  wire  logic signed [INTEG_W-1:0]  integ,
   input  wire  logic [GAIN_W-1:0]          prop_gain,
   input  wire  logic [GAIN_W-1:0]          integ_gain,
   output       mcpi_unit_status_type       status,
   output       logic signed [U_W-1:0]      drive
);

   localparam int CNT_W = $clog2(GAIN_W + 1);

   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [MAC_HI_W-1:0] hi_ff, hi_in;
   logic [GAIN_W-1:0]          kp_sr_ff, kp_sr_in;
   logic [GAIN_W-1:0]          ki_sr_ff, ki_sr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic signed [MAC_HI_W-1:0] term_p;
   logic signed [MAC_HI_W-1:0] term_i;
   logic signed [MAC_HI_W-1:0] sum;

   always_comb begin
      term_p = kp_sr_ff[0] ? {{(MAC_HI_W-ERR_W){err_ff[ERR_W-1]}}, err_ff} : '0;
      term_i = ki_sr_ff[0] ? {{(MAC_HI_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff} : '0;
      sum    = hi_ff + term_p + term_i;

      err_in   = err_ff;
      integ_in = integ_ff;
      hi_in    = hi_ff;
      kp_sr_in = kp_sr_ff;
      ki_sr_in = ki_sr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         err_in   = err;
         integ_in = integ;
         hi_in    = '0;
         kp_sr_in = prop_gain;
         ki_sr_in = integ_gain;
         cnt_in   = CNT_W'(GAIN_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in    = {sum[MAC_HI_W-1], sum[MAC_HI_W-1:1]};
         kp_sr_in = {sum[0], kp_sr_ff[GAIN_W-1:1]};
         ki_sr_in = {1'b0, ki_sr_ff[GAIN_W-1:1]};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      err_ff   <= err_in;
      integ_ff <= integ_in;
      hi_ff    <= hi_in;
      kp_sr_ff <= kp_sr_in;
      ki_sr_ff <= ki_sr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign drive       = {hi_ff, kp_sr_ff};

endmodule

`default_nettype wire

[design/mcpi_scale.sv]
// Serial scaling of the drive magnitude to a compare value: mag*period, then /4096/100.
// Shift-add multiply one bit per cycle, then restoring division by 100 one bit per cycle.
// Depends on mcpi_pkg.
`default_nettype none

module mcpi_scale
   import mcpi_pkg::*;
(
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 start,
   input  wire  logic [MAG_W-1:0]     mag,
   input  wire  logic [PERIOD_W-1:0]  period,
   output       mcpi_unit_status_type status,
   output       logic [CMP_W-1:0]     compare
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   typedef enum logic [2:0] {
      SC_IDLE = 3'b001,
      SC_MUL  = 3'b010,
      SC_DIV  = 3'b100
   } scale_state_type;

   scale_state_type         state_ff, state_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [MAG_W-1:0]        hi_ff, hi_in;
   logic [PERIOD_W-1:0]     lo_ff, lo_in;
   logic [DIVIDEND_W-1:0]   div_ff, div_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [MAG_W:0]          mul_sum;
   logic [REM_W:0]          trial;
   logic                    trial_ge;

   always_comb begin
      mul_sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mag_ff} : '0);
      trial    = {rem_ff, div_ff[DIVIDEND_W-1]};
      trial_ge = trial >= PERCENT_SCALE;

      state_in = state_ff;
      mag_in   = mag_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               mag_in   = mag;
               hi_in    = '0;
               lo_in    = period;
               cnt_in   = CNT_W'(PERIOD_W);
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            hi_in  = mul_sum[MAG_W:1];
            lo_in  = {mul_sum[0], lo_ff[PERIOD_W-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               div_in   = {hi_in, lo_in[PERIOD_W-1:FRAC_BITS]};
               rem_in   = '0;
               cnt_in   = CNT_W'(DIVIDEND_W);
               state_in = SC_DIV;
            end
         end
         SC_DIV: begin
            rem_in = trial_ge ? REM_W'(trial - PERCENT_SCALE) : trial[REM_W-1:0];
            div_in = {div_ff[DIVIDEND_W-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      mag_ff <= mag_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign status.busy = (state_ff != SC_IDLE);
   assign status.done = done_ff;
   assign compare     = div_ff[CMP_W-1:0];

endmodule

`default_nettype wire

[design/motor_current_pi_controller_top.sv]
// Top level of the motor current PI controller: registers, mode logic, sequencer, output stage.
// Depends on mcpi_pkg, mcpi_pi_mac, mcpi_scale and assert_macros.svh.
//
//   Port group   Direction   Flow control    Moves
//   req_*        in          valid / stall   one control tick item
//   rsp_*        out         valid / stall   one drive result item
//   csr_*        in          valid / ready   one register write
//
// From acceptance to rsp_valid an item passes through the serial PI multiply-accumulate,
// the serial multiply by the PWM period and the serial divide by 100.
// A new item is accepted only once the last one is loaded into the output register.
// A finished result waits in the output register while the next item is accepted.
// Reset is synchronous; it restores the register defaults and clears the integrator and test state.
`default_nettype none
`include "assert_macros.svh"

module motor_current_pi_controller_top
   import mcpi_pkg::*;
#(
   parameter int TEST_LENGTH = 100
) (
   input  wire  logic                         clock,
   input  wire  logic                         reset,
   input  wire  logic                         req_valid,
   output       logic                         req_stall,
   input  wire  logic signed [MEAS_W-1:0]     req_measured_current,
   input  wire  logic signed [MEAS_W-1:0]     req_target_current,
   input  wire  logic                         req_clear_integral,
   output       logic                         rsp_valid,
   input  wire  logic                         rsp_stall,
   output       logic [CMP_W-1:0]             rsp_compare_value,
   output       logic                         rsp_direction_forward,
   output       logic signed [REF_W-1:0]      rsp_test_reference,
   output       logic [INDEX_W-1:0]           rsp_test_index,
   output       logic                         rsp_test_done,
   input  wire  logic                         csr_valid,
   output       logic                         csr_ready,
   input  wire  logic [CSR_IDX_W-1:0]         csr_index,
   input  wire  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int CNT_W = $clog2(TEST_LENGTH);
   localparam int QUARTER = TEST_LENGTH / 4;
   localparam logic [CNT_W-1:0]   COUNT_Q1   = CNT_W'(QUARTER);
   localparam logic [CNT_W-1:0]   COUNT_Q2   = CNT_W'(2 * QUARTER);
   localparam logic [CNT_W-1:0]   COUNT_Q3   = CNT_W'(3 * QUARTER);
   localparam logic [CNT_W-1:0]   COUNT_LAST = CNT_W'(TEST_LENGTH - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(TEST_LENGTH - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAC   = 5'b00010,
      ST_SAT   = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_SEND  = 5'b10000
   } ctl_state_type;

   ctl_state_type              state_ff, state_in;
   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic signed [DUTY_W-1:0]   duty_ff, duty_in;
   logic [GAIN_W-1:0]          prop_gain_ff, prop_gain_in;
   logic [GAIN_W-1:0]          integ_gain_ff, integ_gain_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic signed [INTEG_W-1:0]  integral_ff, integral_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       ref_pos_ff, ref_pos_in;
   logic                       finished_ff, finished_in;
   logic [MODE_W-1:0]          pend_mode_ff, pend_mode_in;
   logic signed [REF_W-1:0]    pend_ref_ff, pend_ref_in;
   logic [INDEX_W-1:0]         pend_index_ff, pend_index_in;
   logic                       pend_done_ff, pend_done_in;
   logic                       dir_ff, dir_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0]           rsp_compare_ff, rsp_compare_in;
   logic                       rsp_dir_ff, rsp_dir_in;
   logic signed [REF_W-1:0]    rsp_ref_ff, rsp_ref_in;
   logic [INDEX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic                       rsp_done_ff, rsp_done_in;

   logic                       req_accept;
   logic                       csr_write;
   logic                       out_load;
   logic [MODE_W-1:0]          eff_mode;
   logic                       is_test;
   logic signed [INTEG_W-1:0]  integ_base;
   logic                       ref_flip;
   logic                       ref_pos_now;
   logic signed [REF_W-1:0]    test_ref;
   logic signed [ERR_W-1:0]    target_ext;
   logic signed [ERR_W-1:0]    err;
   logic signed [INTEG_W:0]    integ_sum;
   logic signed [INTEG_W-1:0]  integ_sat;
   logic signed [INTEG_W-1:0]  integ_clamp;
   logic signed [INTEG_W-1:0]  integ_next;
   logic signed [DUTY_W-1:0]   duty_abs;
   logic signed [U_W-1:0]      drive_abs;
   logic [MAG_W-1:0]           sat_mag;
   logic                       sat_dir;
   logic                       mac_start;
   logic                       scale_start;
   mcpi_unit_status_type       mac_status;
   mcpi_unit_status_type       scale_status;
   logic signed [U_W-1:0]      mac_drive;
   logic [CMP_W-1:0]           scale_compare;

   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);

   // Tick arithmetic: effective mode, test reference, error and integrator update.
   always_comb begin
      unique case (mode_ff) inside
         MODE_OPEN:             eff_mode = MODE_OPEN;
         MODE_TEST:             eff_mode = finished_ff ? MODE_IDLE : MODE_TEST;
         MODE_HOLD, MODE_TRACK: eff_mode = mode_ff;
         default:               eff_mode = MODE_IDLE;
      endcase
      is_test     = (eff_mode == MODE_TEST);
      integ_base  = req_clear_integral ? '0 : integral_ff;
      ref_flip    = (count_ff == COUNT_Q1) || (count_ff == COUNT_Q2) || (count_ff == COUNT_Q3);
      ref_pos_now = ref_pos_ff ^ ref_flip;
      test_ref    = ref_pos_now ? TEST_AMPLITUDE : TEST_AMPLITUDE_NEG;
      target_ext  = is_test ? {{(ERR_W-REF_W){test_ref[REF_W-1]}}, test_ref}
                            : {req_target_current[MEAS_W-1], req_target_current};
      err         = target_ext - {req_measured_current[MEAS_W-1], req_measured_current};
      integ_sum   = {integ_base[INTEG_W-1], integ_base}
                  + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};

      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end

      if (integ_sum > INTEG_LIMIT) begin
         integ_clamp = INTEG_LIMIT[INTEG_W-1:0];
      end else if (integ_sum < INTEG_LIMIT_NEG) begin
         integ_clamp = INTEG_LIMIT_NEG[INTEG_W-1:0];
      end else begin
         integ_clamp = integ_sum[INTEG_W-1:0];
      end

      unique case (eff_mode) inside
         MODE_TEST:             integ_next = integ_sat;
         MODE_HOLD, MODE_TRACK: integ_next = integ_clamp;
         default:               integ_next = integ_base;
      endcase
   end

   // Drive saturation and magnitude for the scaling unit.
   always_comb begin
      if (duty_ff > DUTY_MAX) begin
         duty_abs = DUTY_MAX;
      end else if (duty_ff < DUTY_MIN) begin
         duty_abs = DUTY_MAX;
      end else begin
         duty_abs = duty_ff[DUTY_W-1] ? -duty_ff : duty_ff;
      end
      drive_abs = mac_drive[U_W-1] ? -mac_drive : mac_drive;

      unique case (pend_mode_ff) inside
         MODE_OPEN: begin
            sat_mag = {duty_abs[DUTY_MAG_W-1:0], {FRAC_BITS{1'b0}}};
            sat_dir = !duty_ff[DUTY_W-1];
         end
         MODE_TEST, MODE_HOLD, MODE_TRACK: begin
            if (mac_drive > FULL_DRIVE) begin
               sat_mag = FULL_MAG;
               sat_dir = 1'b1;
            end else if (mac_drive < FULL_DRIVE_NEG) begin
               sat_mag = FULL_MAG;
               sat_dir = 1'b0;
            end else begin
               sat_mag = drive_abs[MAG_W-1:0];
               sat_dir = !mac_drive[U_W-1];
            end
         end
         default: begin
            sat_mag = '0;
            sat_dir = 1'b0;
         end
      endcase
   end

   // Sequencer, state updates, output register and register writes.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      duty_in        = duty_ff;
      prop_gain_in   = prop_gain_ff;
      integ_gain_in  = integ_gain_ff;
      period_in      = period_ff;
      integral_in    = integral_ff;
      count_in       = count_ff;
      ref_pos_in     = ref_pos_ff;
      finished_in    = finished_ff;
      pend_mode_in   = pend_mode_ff;
      pend_ref_in    = pend_ref_ff;
      pend_index_in  = pend_index_ff;
      pend_done_in   = pend_done_ff;
      dir_in         = dir_ff;
      rsp_compare_in = rsp_compare_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_ref_in     = rsp_ref_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_done_in    = rsp_done_ff;
      mac_start      = 1'b0;
      scale_start    = 1'b0;
      out_load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mac_start     = 1'b1;
               integral_in   = integ_next;
               pend_mode_in  = eff_mode;
               pend_ref_in   = '0;
               pend_index_in = '0;
               pend_done_in  = 1'b0;
               if (is_test) begin
                  pend_ref_in   = test_ref;
                  pend_index_in = INDEX_W'(count_ff);
                  if (count_ff == COUNT_LAST) begin
                     pend_done_in = 1'b1;
                     count_in     = '0;
                     ref_pos_in   = 1'b1;
                     finished_in  = 1'b1;
                  end else begin
                     count_in   = count_ff + 1'b1;
                     ref_pos_in = ref_pos_now;
                  end
               end
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_status.done) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            scale_start = 1'b1;
            dir_in      = sat_dir;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_status.done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_compare_in = scale_compare;
         rsp_dir_in     = dir_ff;
         rsp_ref_in     = pend_ref_ff;
         rsp_index_in   = pend_index_ff;
         rsp_done_in    = pend_done_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in     = csr_data[MODE_W-1:0];
               finished_in = 1'b0;
            end
            CSR_DUTY: duty_in = csr_data[DUTY_W-1:0];
            CSR_PROP_GAIN: begin
               prop_gain_in = csr_data[GAIN_W-1:0];
               integral_in  = '0;
            end
            CSR_INTEG_GAIN: begin
               integ_gain_in = csr_data[GAIN_W-1:0];
               integral_in   = '0;
            end
            CSR_PERIOD: period_in = csr_data[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_IDLE;
         duty_ff       <= '0;
         prop_gain_ff  <= PROP_GAIN_RESET;
         integ_gain_ff <= INTEG_GAIN_RESET;
         period_ff     <= PERIOD_RESET;
         integral_ff   <= '0;
         count_ff      <= '0;
         ref_pos_ff    <= 1'b1;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         duty_ff       <= duty_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         period_ff     <= period_in;
         integral_ff   <= integral_in;
         count_ff      <= count_in;
         ref_pos_ff    <= ref_pos_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_mode_ff   <= pend_mode_in;
      pend_ref_ff    <= pend_ref_in;
      pend_index_ff  <= pend_index_in;
      pend_done_ff   <= pend_done_in;
      dir_ff         <= dir_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_ref_ff     <= rsp_ref_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_done_ff    <= rsp_done_in;
   end

   mcpi_pi_mac u_pi_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (mac_start),
      .err        (err),
      .integ      (integ_next),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .status     (mac_status),
      .drive      (mac_drive)
   );

   mcpi_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .mag     (sat_mag),
      .period  (period_ff),
      .status  (scale_status),
      .compare (scale_compare)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_compare_value     = rsp_compare_ff;
   assign rsp_direction_forward = rsp_dir_ff;
   assign rsp_test_reference    = rsp_ref_ff;
   assign rsp_test_index        = rsp_index_ff;
   assign rsp_test_done         = rsp_done_ff;

   `MCPI_ASSERT_NEXT(a_accept_starts_mac, req_accept, (state_ff == ST_MAC) && mac_status.busy, "Accepted item did not start the multiply-accumulate.")
   `MCPI_ASSERT_IMPLY(a_mac_owned, mac_status.busy || mac_status.done, state_ff == ST_MAC, "Multiply-accumulate active outside its sequencer state.")
   `MCPI_ASSERT_IMPLY(a_scale_owned, scale_status.busy || scale_status.done, state_ff == ST_SCALE, "Scaling unit active outside its sequencer state.")
   `MCPI_ASSERT_IMPLY(a_done_on_last, rsp_valid && rsp_test_done, rsp_test_index == INDEX_LAST, "Test done flagged on a sample other than the last.")

endmodule

`default_nettype wire
